@@ hdl/dpb_pkg.sv @@
package dpb_pkg;

    localparam int MAG_W  = 16;
    localparam int Z_W    = 20;
    localparam int PROD_W = MAG_W + Z_W;
    localparam int DIV_STAGES = PROD_W;
    localparam int NUM_STAGES = DIV_STAGES + 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL_X  = 3'd0,
        CFG_FOCAL_Y  = 3'd1,
        CFG_CENTER_X = 3'd2,
        CFG_CENTER_Y = 3'd3,
        CFG_DEPTH_MIN = 3'd4,
        CFG_DEPTH_MAX = 3'd5
    } cfg_index_t;

    localparam logic [15:0] FOCAL_X_RST   = 16'd8400;
    localparam logic [15:0] FOCAL_Y_RST   = 16'd8400;
    localparam logic [15:0] CENTER_X_RST  = 16'd5120;
    localparam logic [15:0] CENTER_Y_RST  = 16'd3840;
    localparam logic [15:0] DEPTH_MIN_RST = 16'd200;
    localparam logic [15:0] DEPTH_MAX_RST = 16'd1000;

    typedef struct packed {
        logic [11:0] column;
        logic [11:0] row;
        logic [15:0] depth_mm;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } pix_t;

    typedef struct packed {
        logic               point_valid;
        logic signed [31:0] x_pos;
        logic signed [31:0] y_pos;
        logic [19:0]        z_pos;
        logic [7:0]         red_out;
        logic [7:0]         green_out;
        logic [7:0]         blue_out;
    } point_t;

    typedef struct packed {
        logic              ok;
        logic              x_neg;
        logic              x_zero;
        logic [MAG_W-1:0]  x_rem;
        logic [PROD_W-1:0] x_work;
        logic              y_neg;
        logic              y_zero;
        logic [MAG_W-1:0]  y_rem;
        logic [PROD_W-1:0] y_work;
        logic [Z_W-1:0]    z16;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
    } stage_t;

    typedef struct packed {
        logic [MAG_W-1:0]  rem;
        logic [PROD_W-1:0] work;
    } div_t;

    // One restoring division step: the dividend shifts out at the top of work while
    // quotient bits shift in at the bottom.
    function automatic div_t div_step(input logic [MAG_W-1:0] rem,
                                      input logic [PROD_W-1:0] work,
                                      input logic [MAG_W-1:0] divisor);
        logic [MAG_W:0] trial;
        logic           qbit;
        div_t           res;
        trial = {rem, work[PROD_W-1]};
        qbit  = (trial >= {1'b0, divisor});
        if (qbit)
        begin
            trial = trial - {1'b0, divisor};
        end
        res.rem  = trial[MAG_W-1:0];
        res.work = {work[PROD_W-2:0], qbit};
        return res;
    endfunction

    function automatic logic signed [31:0] saturate(input logic [PROD_W-1:0] q,
                                                    input logic neg,
                                                    input logic zero);
        logic signed [31:0] res;
        if (zero)
        begin
            res = 32'sd0;
        end
        else if (neg)
        begin
            if (q > PROD_W'(64'h8000_0000))
            begin
                res = 32'sh8000_0000;
            end
            else
            begin
                res = 32'sd0 - $signed(q[31:0]);
            end
        end
        else
        begin
            if (q > PROD_W'(64'h7FFF_FFFF))
            begin
                res = 32'sh7FFF_FFFF;
            end
            else
            begin
                res = $signed(q[31:0]);
            end
        end
        return res;
    endfunction

endpackage

@@ hdl/depth_pixel_backprojection.sv @@
// Path: input stage, multiply stage, divider stages, then the output register.
// Throughput: one item per cycle unless stalled; 36-stage divider, one quotient bit per stage.
// Each stage advances whenever the stage after it is empty or moving, so bubbles close up.
// Reset: asynchronous, active low; clears all valid bits and loads the default intrinsics
// and depth limits.
module depth_pixel_backprojection (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pix_valid,
    output logic                                 pix_stall,
    input  dpb_pkg::pix_t                        pix,
    output logic                                 pt_valid,
    input  logic                                 pt_stall,
    output dpb_pkg::point_t                      pt,
    input  logic                                 cfg_write,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import dpb_pkg::*;

    logic [15:0] focal_x_reg;
    logic [15:0] focal_y_reg;
    logic [15:0] center_x_reg;
    logic [15:0] center_y_reg;
    logic [15:0] depth_min_reg;
    logic [15:0] depth_max_reg;

    stage_t stage_reg  [NUM_STAGES];
    stage_t stage_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES:0]   rdy;

    point_t pt_reg;
    point_t pt_next;
    logic   pt_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg   <= FOCAL_X_RST;
            focal_y_reg   <= FOCAL_Y_RST;
            center_x_reg  <= CENTER_X_RST;
            center_y_reg  <= CENTER_Y_RST;
            depth_min_reg <= DEPTH_MIN_RST;
            depth_max_reg <= DEPTH_MAX_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_FOCAL_X:   focal_x_reg   <= cfg_data;
                CFG_FOCAL_Y:   focal_y_reg   <= cfg_data;
                CFG_CENTER_X:  center_x_reg  <= cfg_data;
                CFG_CENTER_Y:  center_y_reg  <= cfg_data;
                CFG_DEPTH_MIN: depth_min_reg <= cfg_data;
                CFG_DEPTH_MAX: depth_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rdy[NUM_STAGES] = !pt_valid_reg || !pt_stall;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    assign pix_stall = !rdy[0];

    // The first stage checks the depth limits and forms the offset magnitudes.
    always_comb
    begin
        logic signed [16:0] num_x;
        logic signed [16:0] num_y;
        logic [16:0]        abs_x;
        logic [16:0]        abs_y;
        num_x = $signed({1'b0, pix.column, 4'b0000}) - $signed({1'b0, center_x_reg});
        num_y = $signed({1'b0, pix.row, 4'b0000}) - $signed({1'b0, center_y_reg});
        abs_x = num_x[16] ? (17'd0 - num_x) : num_x;
        abs_y = num_y[16] ? (17'd0 - num_y) : num_y;
        stage_next[0].ok     = (pix.depth_mm >= depth_min_reg) &&
                               (pix.depth_mm <= depth_max_reg);
        stage_next[0].x_neg  = num_x[16];
        stage_next[0].x_zero = (num_x == 17'sd0) || (pix.depth_mm == 16'd0);
        stage_next[0].x_rem  = '0;
        stage_next[0].x_work = {{(PROD_W-MAG_W){1'b0}}, abs_x[MAG_W-1:0]};
        stage_next[0].y_neg  = num_y[16];
        stage_next[0].y_zero = (num_y == 17'sd0) || (pix.depth_mm == 16'd0);
        stage_next[0].y_rem  = '0;
        stage_next[0].y_work = {{(PROD_W-MAG_W){1'b0}}, abs_y[MAG_W-1:0]};
        stage_next[0].z16    = {pix.depth_mm, 4'b0000};
        stage_next[0].red    = pix.red;
        stage_next[0].green  = pix.green;
        stage_next[0].blue   = pix.blue;
    end

    always_comb
    begin
        stage_next[1] = stage_reg[0];
        stage_next[1].x_work = stage_reg[0].x_work[MAG_W-1:0] * stage_reg[0].z16;
        stage_next[1].y_work = stage_reg[0].y_work[MAG_W-1:0] * stage_reg[0].z16;
    end

    for (genvar s = 2; s < NUM_STAGES; s++)
    begin : g_div
        always_comb
        begin
            div_t dx;
            div_t dy;
            dx = div_step(stage_reg[s-1].x_rem, stage_reg[s-1].x_work, focal_x_reg);
            dy = div_step(stage_reg[s-1].y_rem, stage_reg[s-1].y_work, focal_y_reg);
            stage_next[s] = stage_reg[s-1];
            stage_next[s].x_rem  = dx.rem;
            stage_next[s].x_work = dx.work;
            stage_next[s].y_rem  = dy.rem;
            stage_next[s].y_work = dy.work;
        end
    end

    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (rdy[s])
            begin
                valid_reg[s] <= (s == 0) ? pix_valid : valid_reg[(s == 0) ? 0 : s - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s])
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    always_comb
    begin
        stage_t last;
        last = stage_reg[NUM_STAGES-1];
        if (last.ok)
        begin
            pt_next.point_valid = 1'b1;
            pt_next.x_pos       = saturate(last.x_work, last.x_neg, last.x_zero);
            pt_next.y_pos       = saturate(last.y_work, last.y_neg, last.y_zero);
            pt_next.z_pos       = last.z16;
            pt_next.red_out     = last.red;
            pt_next.green_out   = last.green;
            pt_next.blue_out    = last.blue;
        end
        else
        begin
            pt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_valid_reg <= 1'b0;
        end
        else if (rdy[NUM_STAGES])
        begin
            pt_valid_reg <= valid_reg[NUM_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NUM_STAGES])
        begin
            pt_reg <= pt_next;
        end
    end

    assign pt_valid = pt_valid_reg;
    assign pt       = pt_reg;

endmodule
